/* rtl/lrf_pkg.sv */
// Shared types and constants for the rectangle fill command engine.
// No dependencies; every other file in rtl imports this package.
`default_nettype none

package lrf_pkg;

    // Panel coordinates fit 12 bits because panel sizes stay below 4096.
    localparam int COORD_W  = 12;
    // Pixel count of one clipped segment, up to 4095 * 4095.
    localparam int AREA_W   = 24;
    localparam int NUM_SEG  = 4;
    localparam int SEG_IDX_W = 2;

    // Request codes carried in the mode field.
    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_FILL    = 2'd1;
    localparam logic [1:0] MODE_OUTLINE = 2'd2;

    // Panel command bytes.
    localparam logic [7:0] CMD_COLUMN = 8'h2A;
    localparam logic [7:0] CMD_ROW    = 8'h2B;
    localparam logic [7:0] CMD_PIXELS = 8'h2C;

    // Positions within the eleven-byte segment header; the last one is the pixel phase.
    localparam logic [3:0] HDR_COL_CMD = 4'd0;
    localparam logic [3:0] HDR_X1_HI   = 4'd1;
    localparam logic [3:0] HDR_X1_LO   = 4'd2;
    localparam logic [3:0] HDR_X2_HI   = 4'd3;
    localparam logic [3:0] HDR_X2_LO   = 4'd4;
    localparam logic [3:0] HDR_ROW_CMD = 4'd5;
    localparam logic [3:0] HDR_Y1_HI   = 4'd6;
    localparam logic [3:0] HDR_Y1_LO   = 4'd7;
    localparam logic [3:0] HDR_Y2_HI   = 4'd8;
    localparam logic [3:0] HDR_Y2_LO   = 4'd9;
    localparam logic [3:0] HDR_PIX_CMD = 4'd10;
    localparam logic [3:0] HDR_PIXELS  = 4'd11;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] rect_x;
        logic [15:0] rect_y;
        logic [15:0] rect_width;
        logic [15:0] rect_height;
        logic [15:0] fill_color;
    } in_item_t;

    typedef struct packed {
        logic       is_command;
        logic [7:0] bus_byte;
        logic       last_of_request;
    } out_item_t;

    // Inclusive bounds of one clipped segment.
    typedef struct packed {
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] x2;
        logic [COORD_W-1:0] y1;
        logic [COORD_W-1:0] y2;
    } seg_bounds_t;

endpackage

`default_nettype wire

/* rtl/lrf_seg_decode.sv */
// Splits a fill or outline request into up to four clipped segments.
// Depends on lrf_pkg; purely combinational.
`default_nettype none

module lrf_seg_decode #(
    parameter int PANEL_WIDTH  = 320,
    parameter int PANEL_HEIGHT = 240
) (
    input  wire lrf_pkg::in_item_t                          req,
    output lrf_pkg::seg_bounds_t [lrf_pkg::NUM_SEG-1:0]     seg_bounds,
    output logic [lrf_pkg::NUM_SEG-1:0]                     seg_mask
);
    import lrf_pkg::*;

    localparam logic [16:0] PW = 17'(PANEL_WIDTH);
    localparam logic [16:0] PH = 17'(PANEL_HEIGHT);

    typedef struct packed {
        logic        ok;
        seg_bounds_t b;
    } seg_cand_t;

    // Rejects a segment that starts off the panel or is empty, and clips the rest.
    function automatic seg_cand_t clip_seg(input logic [15:0] x, input logic [15:0] y,
                                           input logic [15:0] w, input logic [15:0] h);
        seg_cand_t   r;
        logic [16:0] xe;
        logic [16:0] ye;
        xe = {1'b0, x} + {1'b0, w};
        ye = {1'b0, y} + {1'b0, h};
        r.ok   = ({1'b0, x} < PW) && ({1'b0, y} < PH) && (w != 16'd0) && (h != 16'd0);
        r.b.x1 = COORD_W'(x);
        r.b.y1 = COORD_W'(y);
        r.b.x2 = (xe > PW) ? COORD_W'(PW - 17'd1) : COORD_W'(xe - 17'd1);
        r.b.y2 = (ye > PH) ? COORD_W'(PH - 17'd1) : COORD_W'(ye - 17'd1);
        return r;
    endfunction

    logic        is_fill;
    logic        is_outline;
    logic        size_ok;
    logic [15:0] y_bottom;
    logic [15:0] x_right;
    logic [15:0] top_h;
    seg_cand_t   c0, c1, c2, c3;

    // The outline edges sit at the wrapped far offsets of the rectangle.
    assign is_fill    = (req.mode == MODE_FILL);
    assign is_outline = (req.mode == MODE_OUTLINE);
    assign size_ok    = (req.rect_width != 16'd0) && (req.rect_height != 16'd0);
    assign y_bottom   = req.rect_y + req.rect_height - 16'd1;
    assign x_right    = req.rect_x + req.rect_width - 16'd1;
    assign top_h      = is_fill ? req.rect_height : 16'd1;

    // Top edge (or the whole fill), bottom, left and right.
    assign c0 = clip_seg(req.rect_x, req.rect_y, req.rect_width, top_h);
    assign c1 = clip_seg(req.rect_x, y_bottom, req.rect_width, 16'd1);
    assign c2 = clip_seg(req.rect_x, req.rect_y, 16'd1, req.rect_height);
    assign c3 = clip_seg(x_right, req.rect_y, 16'd1, req.rect_height);

    assign seg_bounds[0] = c0.b;
    assign seg_bounds[1] = c1.b;
    assign seg_bounds[2] = c2.b;
    assign seg_bounds[3] = c3.b;

    assign seg_mask[0] = c0.ok && (is_fill || (is_outline && size_ok));
    assign seg_mask[1] = c1.ok && is_outline && size_ok;
    assign seg_mask[2] = c2.ok && is_outline && size_ok;
    assign seg_mask[3] = c3.ok && is_outline && size_ok;

endmodule

`default_nettype wire

/* rtl/lrf_sequencer.sv */
// Segment store and byte sequencer: one tick item yields one panel byte.
// Depends on lrf_pkg; fed by lrf_seg_decode, drains into lrf_out_skid.
`default_nettype none

module lrf_sequencer (
    input  wire                                             clk,
    input  wire                                             rst_n,
    input  wire                                             take,
    input  wire lrf_pkg::in_item_t                          req,
    input  wire lrf_pkg::seg_bounds_t [lrf_pkg::NUM_SEG-1:0] dec_bounds,
    input  wire [lrf_pkg::NUM_SEG-1:0]                      dec_mask,
    output logic                                            res_valid,
    output lrf_pkg::out_item_t                              res_item
);
    import lrf_pkg::*;

    logic                    busy_reg, busy_next;
    logic [NUM_SEG-1:0]      mask_reg, mask_next;
    logic [SEG_IDX_W-1:0]    seg_idx_reg, seg_idx_next;
    logic [3:0]              hdr_reg, hdr_next;
    logic [AREA_W-1:0]       pixels_reg, pixels_next;
    logic                    low_reg, low_next;
    logic [15:0]             color_reg, color_next;

    seg_bounds_t             bounds_mem [NUM_SEG];
    seg_bounds_t             cur;
    logic                    start;
    logic                    tick;
    logic                    first_found;
    logic [SEG_IDX_W-1:0]    first_idx;
    logic                    nxt_found;
    logic [SEG_IDX_W-1:0]    nxt_idx;
    logic [15:0]             x1_w, x2_w, y1_w, y2_w;
    logic [COORD_W:0]        span_x, span_y;
    logic [2*COORD_W+1:0]    area_full;
    logic [AREA_W-1:0]       pixels_dec;
    logic                    seg_done;

    assign start = take && !busy_reg && ((req.mode == MODE_FILL) || (req.mode == MODE_OUTLINE));
    assign tick  = take && busy_reg && (req.mode == MODE_TICK);

    // Lowest kept segment of a new request.
    always_comb
    begin
        first_found = 1'b0;
        first_idx   = '0;
        for (int i = NUM_SEG - 1; i >= 0; i--)
        begin
            if (dec_mask[i])
            begin
                first_found = 1'b1;
                first_idx   = SEG_IDX_W'(i);
            end
        end
    end

    // Next kept segment after the current one.
    always_comb
    begin
        nxt_found = 1'b0;
        nxt_idx   = '0;
        for (int i = NUM_SEG - 1; i >= 0; i--)
        begin
            if (mask_reg[i] && (SEG_IDX_W'(i) > seg_idx_reg))
            begin
                nxt_found = 1'b1;
                nxt_idx   = SEG_IDX_W'(i);
            end
        end
    end

    // Current segment bounds, widened to the 16-bit bus coordinates.
    assign cur  = bounds_mem[seg_idx_reg];
    assign x1_w = 16'(cur.x1);
    assign x2_w = 16'(cur.x2);
    assign y1_w = 16'(cur.y1);
    assign y2_w = 16'(cur.y2);

    // Pixel count of the segment, taken when the pixel command goes out.
    assign span_x     = {1'b0, cur.x2} - {1'b0, cur.x1} + (COORD_W+1)'(1);
    assign span_y     = {1'b0, cur.y2} - {1'b0, cur.y1} + (COORD_W+1)'(1);
    assign area_full  = span_x * span_y;
    assign pixels_dec = (pixels_reg != '0) ? pixels_reg - AREA_W'(1) : pixels_reg;

    // Next state and the byte for this tick.
    always_comb
    begin
        busy_next    = busy_reg;
        mask_next    = mask_reg;
        seg_idx_next = seg_idx_reg;
        hdr_next     = hdr_reg;
        pixels_next  = pixels_reg;
        low_next     = low_reg;
        color_next   = color_reg;
        seg_done     = 1'b0;
        res_valid    = tick;
        res_item     = '0;

        if (start)
        begin
            mask_next = dec_mask;
            if (first_found)
            begin
                busy_next    = 1'b1;
                seg_idx_next = first_idx;
                hdr_next     = HDR_COL_CMD;
                pixels_next  = '0;
                low_next     = 1'b0;
                color_next   = req.fill_color;
            end
        end
        else if (tick)
        begin
            if (hdr_reg != HDR_PIXELS)
            begin
                case (hdr_reg)
                    HDR_COL_CMD:
                    begin
                        res_item.is_command = 1'b1;
                        res_item.bus_byte   = CMD_COLUMN;
                    end
                    HDR_X1_HI: res_item.bus_byte = x1_w[15:8];
                    HDR_X1_LO: res_item.bus_byte = x1_w[7:0];
                    HDR_X2_HI: res_item.bus_byte = x2_w[15:8];
                    HDR_X2_LO: res_item.bus_byte = x2_w[7:0];
                    HDR_ROW_CMD:
                    begin
                        res_item.is_command = 1'b1;
                        res_item.bus_byte   = CMD_ROW;
                    end
                    HDR_Y1_HI: res_item.bus_byte = y1_w[15:8];
                    HDR_Y1_LO: res_item.bus_byte = y1_w[7:0];
                    HDR_Y2_HI: res_item.bus_byte = y2_w[15:8];
                    HDR_Y2_LO: res_item.bus_byte = y2_w[7:0];
                    default:
                    begin
                        res_item.is_command = 1'b1;
                        res_item.bus_byte   = CMD_PIXELS;
                        pixels_next         = AREA_W'(area_full);
                        low_next            = 1'b0;
                    end
                endcase
                hdr_next = hdr_reg + 4'd1;
            end
            else if (low_reg)
            begin
                res_item.bus_byte = color_reg[7:0];
                low_next          = 1'b0;
                pixels_next       = pixels_dec;
                seg_done          = (pixels_dec == '0);
            end
            else
            begin
                res_item.bus_byte = color_reg[15:8];
                low_next          = 1'b1;
            end

            // Move to the next kept segment or close the request.
            if (seg_done)
            begin
                hdr_next = HDR_COL_CMD;
                if (nxt_found)
                begin
                    seg_idx_next = nxt_idx;
                end
                else
                begin
                    res_item.last_of_request = 1'b1;
                    busy_next                = 1'b0;
                    seg_idx_next             = '0;
                end
            end
        end
    end

    // Control and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            mask_reg    <= '0;
            seg_idx_reg <= '0;
            hdr_reg     <= HDR_COL_CMD;
            pixels_reg  <= '0;
            low_reg     <= 1'b0;
            color_reg   <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            mask_reg    <= mask_next;
            seg_idx_reg <= seg_idx_next;
            hdr_reg     <= hdr_next;
            pixels_reg  <= pixels_next;
            low_reg     <= low_next;
            color_reg   <= color_next;
        end
    end

    // Segment store; only entries marked in the mask are ever read.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            for (int i = 0; i < NUM_SEG; i++)
            begin
                bounds_mem[i] <= dec_bounds[i];
            end
        end
    end

`ifndef ASSERT_OFF
    a_cur_seg_kept: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> mask_reg[seg_idx_reg])
        else $error("active segment is not marked as kept");

    a_hdr_range: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_reg <= HDR_PIXELS)
        else $error("header position out of range");

    a_pixels_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && (hdr_reg == HDR_PIXELS)) |-> (pixels_reg != '0))
        else $error("pixel phase with no pixels left");

    a_last_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_item.last_of_request) |=> !busy_reg)
        else $error("engine still busy after the final byte");
`endif

endmodule

`default_nettype wire

/* rtl/lrf_out_skid.sv */
// Two-entry output register that holds result items while the sink stalls.
// Depends on lrf_pkg for the result item type.
`default_nettype none

module lrf_out_skid (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     push_valid,
    input  wire lrf_pkg::out_item_t push_item,
    output logic                    full,
    output logic                    out_valid,
    output lrf_pkg::out_item_t      out_item,
    input  wire                     out_stall
);
    import lrf_pkg::*;

    logic      main_valid_reg;
    logic      skid_valid_reg;
    out_item_t main_item_reg;
    out_item_t skid_item_reg;
    logic      out_take;

    assign out_take  = main_valid_reg && !out_stall;
    assign out_valid = main_valid_reg;
    assign out_item  = main_item_reg;
    assign full      = skid_valid_reg;

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push_valid)
        begin
            if (main_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            main_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                main_item_reg <= skid_item_reg;
            end
        end
        else if (push_valid)
        begin
            if (!main_valid_reg || out_take)
            begin
                main_item_reg <= push_item;
            end
            else
            begin
                skid_item_reg <= push_item;
            end
        end
    end

`ifndef ASSERT_OFF
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held with an empty output register");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !push_valid)
        else $error("item pushed into a full output buffer");

    a_held_push_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && main_valid_reg && out_stall) |=> skid_valid_reg)
        else $error("item lost while the output was stalled");
`endif

endmodule

`default_nettype wire

/* rtl/lcd_rect_fill_command_engine.sv */
// Top level of the rectangle fill command engine for a 16-bit color panel.
// Depends on lrf_pkg, lrf_seg_decode, lrf_sequencer and lrf_out_skid.
//
// A start item (fill or outline) loads up to four clipped segments and gives no
// byte; every following tick item gives one panel byte, so one item is accepted
// and one byte produced in every cycle while in_stall is low. Each byte is
// registered in the output buffer, in its skid entry if the sink stalls. The rate
// is set by the segment sequencer, which updates its counters once per accepted
// item, and by the two-entry output buffer, which raises in_stall only when both
// of its entries are held by a stalled sink. Mid-transfer requests are dropped.
`default_nettype none

module lcd_rect_fill_command_engine #(
    parameter int PANEL_WIDTH  = 320,
    parameter int PANEL_HEIGHT = 240
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_stall,
    input  wire lrf_pkg::in_item_t  in_item,
    output logic                    out_valid,
    input  wire                     out_stall,
    output lrf_pkg::out_item_t      out_item
);
    import lrf_pkg::*;

    seg_bounds_t [NUM_SEG-1:0] dec_bounds;
    logic [NUM_SEG-1:0]        dec_mask;
    logic                      take;
    logic                      res_valid;
    out_item_t                 res_item;
    logic                      buf_full;

    assign in_stall = buf_full;
    assign take     = in_valid && !buf_full;

    lrf_seg_decode #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_decode (
        .req        (in_item),
        .seg_bounds (dec_bounds),
        .seg_mask   (dec_mask)
    );

    lrf_sequencer u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .req        (in_item),
        .dec_bounds (dec_bounds),
        .dec_mask   (dec_mask),
        .res_valid  (res_valid),
        .res_item   (res_item)
    );

    lrf_out_skid u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (res_valid),
        .push_item  (res_item),
        .full       (buf_full),
        .out_valid  (out_valid),
        .out_item   (out_item),
        .out_stall  (out_stall)
    );

endmodule

`default_nettype wire

/* dv/lrf_byte_checker.sv */
// Byte stream checker for the rectangle fill command engine.
// Depends on lrf_pkg; watches both channels and counts mismatches for the test top.
`timescale 1ns / 1ps

module lrf_byte_checker #(
    parameter int PANEL_WIDTH  = 320,
    parameter int PANEL_HEIGHT = 240
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    input  wire                 in_stall,
    input  lrf_pkg::in_item_t   in_item,
    input  wire                 out_valid,
    input  wire                 out_stall,
    input  lrf_pkg::out_item_t  out_item,
    output int                  fail_count,
    output int                  pending_count,
    output logic                engine_busy
);
    import lrf_pkg::*;

    // Shadow copy of the engine state.
    logic              busy_m;
    logic [15:0]       seg_x1 [NUM_SEG];
    logic [15:0]       seg_x2 [NUM_SEG];
    logic [15:0]       seg_y1 [NUM_SEG];
    logic [15:0]       seg_y2 [NUM_SEG];
    logic [NUM_SEG-1:0] kept_mask;
    int unsigned       seg_sel;
    logic [3:0]        hdr_pos;
    int unsigned       pixels_left;
    logic              low_next;
    logic [15:0]       color_m;

    // Panel bytes predicted but not yet seen on the output.
    out_item_t         expected_bytes [$];
    int                mismatches;

    task automatic clear_engine_state();
        busy_m      = 1'b0;
        kept_mask   = '0;
        seg_sel     = 0;
        hdr_pos     = HDR_COL_CMD;
        pixels_left = 0;
        low_next    = 1'b0;
        color_m     = '0;
        for (int i = 0; i < NUM_SEG; i++)
        begin
            seg_x1[i] = '0;
            seg_x2[i] = '0;
            seg_y1[i] = '0;
            seg_y2[i] = '0;
        end
    endtask

    // Rejects an off-panel or empty segment, otherwise clips it and marks it kept.
    task automatic clip_segment(input int unsigned slot, input int unsigned x,
                                input int unsigned y, input int unsigned w,
                                input int unsigned h);
        int unsigned cw;
        int unsigned ch;
        cw = w;
        ch = h;
        if (x >= PANEL_WIDTH || y >= PANEL_HEIGHT || w == 0 || h == 0)
            return;
        if (x + cw > PANEL_WIDTH)
            cw = PANEL_WIDTH - x;
        if (y + ch > PANEL_HEIGHT)
            ch = PANEL_HEIGHT - y;
        seg_x1[slot]    = x[15:0];
        seg_x2[slot]    = 16'(x + cw - 1);
        seg_y1[slot]    = y[15:0];
        seg_y2[slot]    = 16'(y + ch - 1);
        kept_mask[slot] = 1'b1;
    endtask

    function automatic int unsigned first_kept(input int unsigned from);
        for (int unsigned i = from; i < NUM_SEG; i++)
            if (kept_mask[i])
                return i;
        return NUM_SEG;
    endfunction

    // Advances the shadow engine by one item and gives the byte it writes, if any.
    task automatic advance_byte_stream(input in_item_t it, output bit produced,
                                       output out_item_t bus_word);
        int unsigned x;
        int unsigned y;
        int unsigned w;
        int unsigned h;
        int unsigned nxt;
        int unsigned span_x;
        int unsigned span_y;
        bit          seg_done;
        produced = 1'b0;
        bus_word = '0;
        seg_done = 1'b0;
        x = it.rect_x;
        y = it.rect_y;
        w = it.rect_width;
        h = it.rect_height;
        case (it.mode)
            MODE_FILL, MODE_OUTLINE:
            begin
                // A request that arrives during a transfer is dropped.
                if (!busy_m)
                begin
                    kept_mask = '0;
                    if (it.mode == MODE_FILL)
                        clip_segment(0, x, y, w, h);
                    else if (w != 0 && h != 0)
                    begin
                        clip_segment(0, x, y, w, 1);
                        clip_segment(1, x, (y + h - 1) & 32'hFFFF, w, 1);
                        clip_segment(2, x, y, 1, h);
                        clip_segment(3, (x + w - 1) & 32'hFFFF, y, 1, h);
                    end
                    nxt = first_kept(0);
                    if (nxt < NUM_SEG)
                    begin
                        busy_m      = 1'b1;
                        seg_sel     = nxt;
                        hdr_pos     = HDR_COL_CMD;
                        pixels_left = 0;
                        low_next    = 1'b0;
                        color_m     = it.fill_color;
                    end
                end
            end
            MODE_TICK:
            begin
                if (busy_m)
                begin
                    produced = 1'b1;
                    if (hdr_pos < HDR_PIXELS)
                    begin
                        case (hdr_pos)
                            HDR_COL_CMD:
                            begin
                                bus_word.is_command = 1'b1;
                                bus_word.bus_byte   = CMD_COLUMN;
                            end
                            HDR_X1_HI: bus_word.bus_byte = seg_x1[seg_sel][15:8];
                            HDR_X1_LO: bus_word.bus_byte = seg_x1[seg_sel][7:0];
                            HDR_X2_HI: bus_word.bus_byte = seg_x2[seg_sel][15:8];
                            HDR_X2_LO: bus_word.bus_byte = seg_x2[seg_sel][7:0];
                            HDR_ROW_CMD:
                            begin
                                bus_word.is_command = 1'b1;
                                bus_word.bus_byte   = CMD_ROW;
                            end
                            HDR_Y1_HI: bus_word.bus_byte = seg_y1[seg_sel][15:8];
                            HDR_Y1_LO: bus_word.bus_byte = seg_y1[seg_sel][7:0];
                            HDR_Y2_HI: bus_word.bus_byte = seg_y2[seg_sel][15:8];
                            HDR_Y2_LO: bus_word.bus_byte = seg_y2[seg_sel][7:0];
                            default:
                            begin
                                bus_word.is_command = 1'b1;
                                bus_word.bus_byte   = CMD_PIXELS;
                                span_x      = int'(seg_x2[seg_sel]) - int'(seg_x1[seg_sel]) + 1;
                                span_y      = int'(seg_y2[seg_sel]) - int'(seg_y1[seg_sel]) + 1;
                                pixels_left = span_x * span_y;
                                low_next    = 1'b0;
                            end
                        endcase
                        hdr_pos = hdr_pos + 4'd1;
                    end
                    else if (low_next)
                    begin
                        bus_word.bus_byte = color_m[7:0];
                        low_next = 1'b0;
                        if (pixels_left > 0)
                            pixels_left--;
                        if (pixels_left == 0)
                            seg_done = 1'b1;
                    end
                    else
                    begin
                        bus_word.bus_byte = color_m[15:8];
                        low_next = 1'b1;
                    end

                    // Move on to the next kept segment or close the request.
                    if (seg_done)
                    begin
                        nxt = first_kept(seg_sel + 1);
                        if (nxt < NUM_SEG)
                        begin
                            seg_sel = nxt;
                            hdr_pos = HDR_COL_CMD;
                        end
                        else
                        begin
                            bus_word.last_of_request = 1'b1;
                            busy_m  = 1'b0;
                            seg_sel = 0;
                            hdr_pos = HDR_COL_CMD;
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic note_failure(input string what, input out_item_t want,
                                input out_item_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected cmd=%0b byte=%02h last=%0b, got cmd=%0b byte=%02h last=%0b",
                     $realtime, what, want.is_command, want.bus_byte, want.last_of_request,
                     got.is_command, got.bus_byte, got.last_of_request);
    endtask

    // Compare accepted bytes first, then predict from the accepted item.
    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        bit        produced;
        out_item_t predicted;
        out_item_t oldest;
        if (!rst_n)
        begin
            clear_engine_state();
            expected_bytes.delete();
            mismatches = 0;
            fail_count    <= 0;
            pending_count <= 0;
            engine_busy   <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_bytes.size() == 0)
                    note_failure("unexpected byte", '0, out_item);
                else
                begin
                    oldest = expected_bytes.pop_front();
                    if (out_item.is_command !== oldest.is_command ||
                        out_item.bus_byte !== oldest.bus_byte ||
                        out_item.last_of_request !== oldest.last_of_request)
                        note_failure("byte mismatch", oldest, out_item);
                end
            end
            if (in_valid && !in_stall)
            begin
                advance_byte_stream(in_item, produced, predicted);
                if (produced)
                    expected_bytes.push_back(predicted);
            end
            fail_count    <= mismatches;
            pending_count <= expected_bytes.size();
            engine_busy   <= busy_m;
        end
    end

endmodule

/* dv/lcd_rect_fill_command_engine_test.sv */
// Test top for the rectangle fill command engine: clock, reset, stimulus and verdict.
// Depends on lrf_pkg, the engine RTL and lrf_byte_checker.
`timescale 1ns / 1ps

module lcd_rect_fill_command_engine_test;
    import lrf_pkg::*;

    localparam int PANEL_W = 320;
    localparam int PANEL_H = 240;
    // Mode code that the engine ignores entirely.
    localparam logic [1:0] MODE_RESERVED = 2'd3;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    in_item_t  in_item = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    out_item_t out_item;

    int        fail_count;
    int        pending_count;
    logic      engine_busy;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned items_sent = 0;

    lcd_rect_fill_command_engine #(
        .PANEL_WIDTH  (PANEL_W),
        .PANEL_HEIGHT (PANEL_H)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    lrf_byte_checker #(
        .PANEL_WIDTH  (PANEL_W),
        .PANEL_HEIGHT (PANEL_H)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_item       (in_item),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_item      (out_item),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .engine_busy   (engine_busy)
    );

    always #5 clk = ~clk;

    // The panel side stalls at random.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    // Hard stop in case the engine hangs.
    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Offers one item, with random gaps before it, and holds it until accepted.
    task automatic send_item(input in_item_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // Item with the given mode and every other field random.
    function automatic in_item_t scrambled(input logic [1:0] mode);
        in_item_t it;
        it.mode        = mode;
        it.rect_x      = 16'($urandom);
        it.rect_y      = 16'($urandom);
        it.rect_width  = 16'($urandom);
        it.rect_height = 16'($urandom);
        it.fill_color  = 16'($urandom);
        return it;
    endfunction

    function automatic in_item_t make_request(input logic [1:0] mode, input int unsigned x,
                                              input int unsigned y, input int unsigned w,
                                              input int unsigned h, input int unsigned color);
        in_item_t it;
        it.mode        = mode;
        it.rect_x      = x[15:0];
        it.rect_y      = y[15:0];
        it.rect_width  = w[15:0];
        it.rect_height = h[15:0];
        it.fill_color  = color[15:0];
        return it;
    endfunction

    // Mostly small in-panel rectangles, with clipped, wrapped, empty and wild ones mixed in.
    function automatic in_item_t random_request();
        in_item_t    it;
        int unsigned kind;
        it = scrambled($urandom_range(1) ? MODE_FILL : MODE_OUTLINE);
        kind = $urandom_range(99);
        if (kind < 70)
        begin
            it.rect_x      = 16'($urandom_range(PANEL_W - 1));
            it.rect_y      = 16'($urandom_range(PANEL_H - 1));
            it.rect_width  = 16'($urandom_range(5, 1));
            it.rect_height = 16'($urandom_range(4, 1));
        end
        else if (kind < 82)
        begin
            // Near the bottom right corner, so huge sizes clip to a few pixels.
            it.rect_x = 16'($urandom_range(PANEL_W - 1, PANEL_W - 10));
            it.rect_y = 16'($urandom_range(PANEL_H - 1, PANEL_H - 10));
        end
        else if (kind < 86)
        begin
            // Width just short of the 16-bit range, so the right edge can wrap around.
            it.rect_x      = 16'($urandom_range(PANEL_W - 1));
            it.rect_y      = 16'($urandom_range(PANEL_H - 1));
            it.rect_width  = 16'(16'hFFFF - $urandom_range(330));
            it.rect_height = 16'($urandom_range(3, 1));
        end
        else if (kind < 94)
        begin
            it.rect_x = 16'($urandom_range(PANEL_W - 1));
            it.rect_y = 16'($urandom_range(PANEL_H - 1));
            if ($urandom_range(1))
                it.rect_width = '0;
            else
                it.rect_height = '0;
        end
        return it;
    endfunction

    // Ticks the engine until the request has finished, with stray starts and noise.
    task automatic run_transfer();
        int unsigned pick;
        do
        begin
            pick = $urandom_range(99);
            if (pick < 3)
                send_item(random_request());
            else if (pick < 5)
                send_item(scrambled(MODE_RESERVED));
            else
                send_item(scrambled(MODE_TICK));
        end
        while (engine_busy);
    endtask

    task automatic start_and_run(input logic [1:0] mode, input int unsigned x,
                                 input int unsigned y, input int unsigned w,
                                 input int unsigned h, input int unsigned color);
        send_item(make_request(mode, x, y, w, h, color));
        run_transfer();
    endtask

    // Holds the sender off until every predicted byte has arrived.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    task automatic run_random(input int unsigned quota);
        int unsigned target;
        target = items_sent + quota;
        while (items_sent < target)
        begin
            if ($urandom_range(99) < 6)
                send_item(scrambled($urandom_range(1) ? MODE_RESERVED : MODE_TICK));
            else
            begin
                send_item(random_request());
                run_transfer();
            end
        end
    endtask

    task automatic run_directed();
        // Idle tick and ignored mode.
        send_item(scrambled(MODE_TICK));
        send_item(scrambled(MODE_RESERVED));

        // Single pixel; starts and noise during the transfer are ignored.
        send_item(make_request(MODE_FILL, 0, 0, 1, 1, 16'hFFFF));
        send_item(make_request(MODE_FILL, 5, 5, 3, 3, 16'h1234));
        send_item(make_request(MODE_OUTLINE, 2, 2, 4, 4, 16'h4321));
        send_item(scrambled(MODE_RESERVED));
        run_transfer();

        // Clipping at the panel edges with the largest sizes.
        start_and_run(MODE_FILL, PANEL_W - 1, PANEL_H - 1, 16'hFFFF, 16'hFFFF, 16'h0000);
        start_and_run(MODE_FILL, PANEL_W - 8, 0, 16'hFFFF, 1, 16'hA5C3);
        start_and_run(MODE_FILL, 0, PANEL_H - 8, 1, 16'hFFFF, 16'h5A3C);

        // Requests whose every segment is rejected.
        start_and_run(MODE_FILL, PANEL_W, 0, 1, 1, 16'h00FF);
        start_and_run(MODE_FILL, 0, PANEL_H, 1, 1, 16'hFF00);
        start_and_run(MODE_FILL, 10, 10, 0, 5, 16'h0F0F);
        start_and_run(MODE_FILL, 10, 10, 5, 0, 16'hF0F0);
        start_and_run(MODE_FILL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        start_and_run(MODE_OUTLINE, 400, 10, 3, 3, 16'h7777);
        start_and_run(MODE_OUTLINE, 10, 10, 0, 3, 16'h8888);

        // Outlines: plain, degenerate, wrapped offsets, extremes and partly off-panel.
        start_and_run(MODE_OUTLINE, 2, 3, 4, 3, 16'hC0DE);
        start_and_run(MODE_OUTLINE, 7, 9, 1, 1, 16'hBEEF);
        start_and_run(MODE_OUTLINE, PANEL_W - 6, 20, 16'hFFFA, 2, 16'h1357);
        start_and_run(MODE_OUTLINE, 30, PANEL_H - 6, 2, 16'hFFFF, 16'h2468);
        start_and_run(MODE_OUTLINE, PANEL_W - 5, PANEL_H - 4, 16'hFFFF, 16'hFFFF, 16'h9ABC);
        start_and_run(MODE_OUTLINE, PANEL_W - 2, PANEL_H - 2, 5, 5, 16'hDEF0);
    endtask

    // Stimulus in three idling phases, then the verdict.
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 6;
        recv_idle_pct = 59;
        run_directed();
        run_random(350);
        drain();

        send_idle_pct = 59;
        recv_idle_pct = 6;
        run_random(350);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(350);
        drain();

        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/lrf_pkg.sv
rtl/lrf_seg_decode.sv
rtl/lrf_sequencer.sv
rtl/lrf_out_skid.sv
rtl/lcd_rect_fill_command_engine.sv
dv/lrf_byte_checker.sv
dv/lcd_rect_fill_command_engine_test.sv
